@@ rtl/core/aes_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES package
// Types, constants and byte functions shared by the AES core modules.
// ----------------------------------------------------------------------------
package aes_pkg;

  localparam int MaxRoundsDefault = 14;
  localparam int Columns          = 4;
  localparam int CfgIdxW          = 3;
  localparam int CfgDataW         = 64;

  typedef enum logic [CfgIdxW-1:0] {
    REG_KEY_MODE = 3'd0,
    REG_KEY_0_7  = 3'd1,
    REG_KEY_8_15 = 3'd2,
    REG_KEY_16_23 = 3'd3,
    REG_KEY_24_31 = 3'd4
  } cfg_reg_e;

  typedef enum logic [1:0] {
    KEY_128 = 2'd0,
    KEY_192 = 2'd1,
    KEY_256 = 2'd2
  } key_mode_e;

  typedef enum logic {
    OP_ENCRYPT = 1'b0,
    OP_DECRYPT = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXP_LOAD,
    ST_EXP_RUN,
    ST_INIT,
    ST_ROUND,
    ST_DONE
  } ctrl_state_e;

  typedef struct packed {
    logic        op;
    logic [63:0] block_high;
    logic [63:0] block_low;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_high;
    logic [63:0] result_low;
  } out_item_t;

  typedef struct packed {
    logic exp_load;
    logic exp_step;
    logic blk_load;
    logic blk_init;
    logic blk_round;
    logic blk_last;
    logic out_valid;
  } dp_cmd_t;

  typedef struct packed {
    logic exp_done;
    logic rd_ready;
  } dp_status_t;

  localparam logic [7:0] Sbox [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] InvSbox [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] b);
    return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {Sbox[w[31:24]], Sbox[w[23:16]], Sbox[w[15:8]], Sbox[w[7:0]]};
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/block_cipher_encrypt_decrypt_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES-128/192/256 ECB core
// Encrypts or decrypts one 16-byte block per item with a configured key.
// ----------------------------------------------------------------------------
// Channel   Signals                         Direction
// cfg       cfg_we_i, cfg_idx_i, cfg_data_i in, write-only
// in        start_i, busy_o, in_item_i      in, taken when start_i && !busy_o
// out       done_o, out_item_o              out, one-cycle strobe
//
// An item runs one round per cycle in the shared round unit. After a key
// write the next item first expands the keys, one word per cycle. Reset
// clears the key registers and the key-ready flag. The result strobe
// cannot be stalled.
// ----------------------------------------------------------------------------
module block_cipher_encrypt_decrypt_core
  import aes_pkg::*;
#(
  parameter int MaxRounds = MaxRoundsDefault
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                start_i,
  input  wire in_item_t            in_item_i,
  output logic                     busy_o,
  output logic                     done_o,
  output out_item_t                out_item_o
);

  logic [1:0]   key_mode_q;
  logic [255:0] key_q;
  logic         cfg_hit;
  dp_cmd_t      cmd;
  dp_status_t   status;
  logic [3:0]   nr;
  logic         busy;

  assign cfg_hit = cfg_we_i && (cfg_idx_i <= REG_KEY_24_31);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_mode_q <= '0;
      key_q      <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KEY_MODE:  key_mode_q       <= cfg_data_i[1:0];
        REG_KEY_0_7:   key_q[255:192]   <= cfg_data_i;
        REG_KEY_8_15:  key_q[191:128]   <= cfg_data_i;
        REG_KEY_16_23: key_q[127:64]    <= cfg_data_i;
        REG_KEY_24_31: key_q[63:0]      <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  aes_ctrl #(.MaxRounds(MaxRounds)) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .cfg_we_i (cfg_hit),
    .nr_i     (nr),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy)
  );

  aes_dp #(.MaxRounds(MaxRounds)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .key_mode_i (key_mode_q),
    .key_i      (key_q),
    .item_i     (in_item_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .nr_o       (nr),
    .valid_o    (done_o),
    .item_o     (out_item_o)
  );

  assign busy_o = busy;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy_o)
    else $error("Result strobe while idle.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o)
    else $error("Item accepted but core not busy.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("Result strobe longer than one cycle.");

endmodule
`default_nettype wire

@@ rtl/core/aes_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES controller
// Sequences key expansion and the rounds of one item.
// ----------------------------------------------------------------------------
module aes_ctrl
  import aes_pkg::*;
#(
  parameter int MaxRounds = MaxRoundsDefault
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       start_i,
  input  wire logic       cfg_we_i,
  input  wire logic [3:0] nr_i,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o,
  output logic            busy_o
);

  ctrl_state_e state_q, state_d;
  logic        keys_ready_q, keys_ready_d;
  logic [3:0]  rnd_q, rnd_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      keys_ready_q <= 1'b0;
      rnd_q        <= '0;
    end else begin
      state_q      <= state_d;
      keys_ready_q <= keys_ready_d;
      rnd_q        <= rnd_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    keys_ready_d = keys_ready_q;
    rnd_d        = rnd_q;
    cmd_o        = '0;
    busy_o       = (state_q != ST_IDLE);
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.blk_load = 1'b1;
          if (keys_ready_q) begin
            state_d = ST_INIT;
          end else begin
            state_d = ST_EXP_LOAD;
          end
        end
      end
      ST_EXP_LOAD: begin
        cmd_o.exp_load = 1'b1;
        state_d        = ST_EXP_RUN;
      end
      ST_EXP_RUN: begin
        if (status_i.exp_done) begin
          keys_ready_d = 1'b1;
          state_d      = ST_INIT;
        end else begin
          cmd_o.exp_step = 1'b1;
        end
      end
      ST_INIT: begin
        if (status_i.rd_ready) begin
          cmd_o.blk_init = 1'b1;
          rnd_d          = 4'd1;
          state_d        = ST_ROUND;
        end
      end
      ST_ROUND: begin
        cmd_o.blk_round = 1'b1;
        cmd_o.blk_last  = (rnd_q == nr_i);
        rnd_d           = rnd_q + 4'd1;
        if (rnd_q == nr_i) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        cmd_o.out_valid = 1'b1;
        state_d         = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cfg_we_i) begin
      keys_ready_d = 1'b0;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND) |-> (rnd_q >= 4'd1 && rnd_q <= 4'(MaxRounds)))
    else $error("Round counter out of range.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_valid |=> (state_q == ST_IDLE))
    else $error("Controller did not return to idle after a result.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXP_RUN && status_i.exp_done) |=> keys_ready_q || $past(cfg_we_i))
    else $error("Key expansion finished without marking keys ready.");

endmodule
`default_nettype wire

@@ rtl/core/aes_dp.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// AES datapath
// Key expansion into the round key memory and one cipher round per cycle.
// ----------------------------------------------------------------------------
module aes_dp
  import aes_pkg::*;
#(
  parameter int MaxRounds = MaxRoundsDefault
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [1:0]    key_mode_i,
  input  wire logic [255:0]  key_i,
  input  wire in_item_t      item_i,
  input  wire dp_cmd_t       cmd_i,
  output dp_status_t         status_o,
  output logic [3:0]         nr_o,
  output logic               valid_o,
  output out_item_t          item_o
);

  localparam int Depth = Columns * (MaxRounds + 1);
  localparam int RowW  = $clog2(MaxRounds + 1);
  localparam int WIdxW = $clog2(Depth + 1);

  logic [2:0]  ksel;
  logic [3:0]  nk;
  logic [3:0]  nr;

  always_comb begin
    ksel = (key_mode_i == 2'd3) ? 3'(KEY_256) : {1'b0, key_mode_i};
    nk   = 4'd4 + {ksel[1:0], 1'b0};
    nr   = (nk + 4'd6 > 4'(MaxRounds)) ? 4'(MaxRounds) : nk + 4'd6;
  end
  assign nr_o = nr;

  // Round key memory, one row of four words per round.
  logic [127:0] rk_mem [MaxRounds+1];

  // Key expansion: a window of up to eight words that holds the last Nk words, one word per cycle.
  logic [31:0]      win_q [8];
  logic [31:0]      win_d [8];
  logic [WIdxW-1:0] wi_q;
  logic [3:0]       pos_q;
  logic [7:0]       rcon_q;
  logic [95:0]      row_q;
  logic [WIdxW-1:0] total;
  logic [31:0]      t_word, new_word;
  logic             exp_busy_q;

  assign total = WIdxW'(Columns) * WIdxW'(nr + 4'd1);

  always_comb begin
    t_word = win_q[nk[2:0] - 3'd1];
    if (nk == 4'd8) begin
      t_word = win_q[7];
    end
    if (pos_q == 4'd0) begin
      t_word = sub_word({t_word[23:0], t_word[31:24]}) ^ {rcon_q, 24'h0};
    end else if (nk == 4'd8 && pos_q == 4'd4) begin
      t_word = sub_word(t_word);
    end
    new_word = win_q[0] ^ t_word;
    for (int k = 0; k < 8; k++) begin
      win_d[k] = win_q[k];
    end
    for (int k = 0; k < 7; k++) begin
      if (4'(k + 1) < nk) begin
        win_d[k] = win_q[k + 1];
      end
    end
    win_d[nk[2:0] - 3'd1] = new_word;
    if (nk == 4'd8) begin
      win_d[7] = new_word;
    end
  end

  logic            wr_en;
  logic [RowW-1:0] wr_row;
  logic [127:0]    wr_data;
  logic [1:0]      cur_col;
  logic [31:0]     cur_word;

  always_comb begin
    cur_col  = wi_q[1:0];
    cur_word = new_word;
    wr_en    = 1'b0;
    wr_data  = {row_q, cur_word};
    wr_row   = RowW'(wi_q >> 2);
    if (exp_busy_q && cmd_i.exp_step && wi_q < total) begin
      if (wi_q < WIdxW'(nk)) begin
        cur_word = win_q[wi_q[2:0]];
      end
      wr_data = {row_q, cur_word};
      wr_en   = (cur_col == 2'd3);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_busy_q <= 1'b0;
    end else if (cmd_i.exp_load) begin
      exp_busy_q <= 1'b1;
    end else if (exp_busy_q && cmd_i.exp_step && wi_q + 1'b1 >= total) begin
      exp_busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exp_load) begin
      for (int k = 0; k < 8; k++) begin
        win_q[k] <= key_i[255 - 32*k -: 32];
      end
      wi_q   <= '0;
      pos_q  <= '0;
      rcon_q <= 8'h01;
    end else if (exp_busy_q && cmd_i.exp_step) begin
      wi_q  <= wi_q + 1'b1;
      row_q <= {row_q[63:0], cur_word};
      if (wi_q >= WIdxW'(nk)) begin
        win_q <= win_d;
        if (pos_q == nk - 4'd1) begin
          pos_q <= '0;
        end else begin
          pos_q <= pos_q + 4'd1;
        end
        if (pos_q == 4'd0) begin
          rcon_q <= xtime(rcon_q);
        end
      end else if (wi_q == WIdxW'(nk) - 1'b1) begin
        pos_q <= '0;
      end
    end
    if (wr_en) begin
      rk_mem[wr_row] <= wr_data;
    end
  end

  assign status_o.exp_done = !exp_busy_q && !cmd_i.exp_load;

  // Round key read: registered, address runs one round ahead.
  logic            dec_q;
  logic [RowW-1:0] rd_row_q, rd_row_d;
  logic [127:0]    rk_q;
  logic            rd_ready_q;

  always_comb begin
    rd_row_d = rd_row_q;
    if (cmd_i.blk_load) begin
      rd_row_d = (item_i.op == OP_DECRYPT) ? RowW'(nr) : '0;
    end else if (cmd_i.blk_init || cmd_i.blk_round) begin
      rd_row_d = dec_q ? rd_row_q - 1'b1 : rd_row_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ready_q <= 1'b0;
      rd_row_q   <= '0;
      dec_q      <= 1'b0;
    end else begin
      rd_row_q   <= rd_row_d;
      rd_ready_q <= status_o.exp_done && !cmd_i.blk_load && !cmd_i.blk_init;
      if (cmd_i.blk_load) begin
        dec_q <= item_i.op;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rk_q <= rk_mem[rd_row_d];
  end
  assign status_o.rd_ready = rd_ready_q;

  // Round logic.
  logic [127:0] st_q, st_d, sb, mx;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        sb[127 - 32*c - 8*r -: 8] = dec_q ?
          InvSbox[st_q[127 - 32*((c + 4 - r) % 4) - 8*r -: 8]] :
          Sbox[st_q[127 - 32*((c + r) % 4) - 8*r -: 8]];
      end
    end
  end

  function automatic logic [31:0] mix_col(input logic [31:0] w, input logic inv);
    logic [7:0] a [4];
    logic [7:0] a2 [4];
    logic [7:0] a4 [4];
    logic [7:0] a8 [4];
    logic [7:0] o [4];
    for (int k = 0; k < 4; k++) begin
      a[k]  = w[31 - 8*k -: 8];
      a2[k] = xtime(a[k]);
      a4[k] = xtime(a2[k]);
      a8[k] = xtime(a4[k]);
    end
    for (int r = 0; r < 4; r++) begin
      if (inv) begin
        o[r] = (a8[r] ^ a4[r] ^ a2[r]) ^ (a8[(r+1)%4] ^ a2[(r+1)%4] ^ a[(r+1)%4]) ^
               (a8[(r+2)%4] ^ a4[(r+2)%4] ^ a[(r+2)%4]) ^ (a8[(r+3)%4] ^ a[(r+3)%4]);
      end else begin
        o[r] = a2[r] ^ (a2[(r+1)%4] ^ a[(r+1)%4]) ^ a[(r+2)%4] ^ a[(r+3)%4];
      end
    end
    return {o[0], o[1], o[2], o[3]};
  endfunction

  function automatic logic [127:0] mix_col_all(input logic [127:0] s);
    logic [127:0] o;
    for (int c = 0; c < 4; c++) begin
      o[127 - 32*c -: 32] = mix_col(s[127 - 32*c -: 32], 1'b0);
    end
    return o;
  endfunction

  logic [127:0] ak;
  always_comb begin
    ak = dec_q ? (sb ^ rk_q) : sb;
    for (int c = 0; c < 4; c++) begin
      mx[127 - 32*c -: 32] = mix_col(ak[127 - 32*c -: 32], dec_q);
    end
    st_d = st_q;
    if (cmd_i.blk_load) begin
      st_d = {item_i.block_high, item_i.block_low};
    end else if (cmd_i.blk_init) begin
      st_d = st_q ^ rk_q;
    end else if (cmd_i.blk_round) begin
      if (dec_q) begin
        st_d = cmd_i.blk_last ? ak : mx;
      end else begin
        st_d = (cmd_i.blk_last ? sb : mix_col_all(sb)) ^ rk_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    st_q <= st_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_o <= 1'b0;
    end else begin
      valid_o <= cmd_i.blk_round && cmd_i.blk_last;
    end
  end

  assign item_o = {st_q[127:64], st_q[63:0]};

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.blk_round |-> !exp_busy_q)
    else $error("Round started during key expansion.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o |-> $past(cmd_i.blk_last))
    else $error("Result without a final round.");
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (wr_row <= RowW'(MaxRounds)))
    else $error("Round key write beyond the memory.");

endmodule
`default_nettype wire

@@ sim/aes_ecb_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES ECB result checker
// Watches the key write port and both item channels. It expands the key
// itself when the first block after a key write arrives, predicts each
// transformed block and compares it with the result that the core returns.
// ----------------------------------------------------------------------------
module aes_ecb_checker
  import aes_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                start_i,
  input  logic                busy_o,
  input  in_item_t            in_item_i,
  input  logic                done_o,
  input  out_item_t           out_item_o,
  output int                  fail_count,
  output int                  pending_blocks
);

  logic [1:0]  mode_q;
  logic [63:0] key_q [4];
  logic [31:0] sched_q [60];
  bit          sched_valid;
  out_item_t   block_queue [$];
  logic [7:0]  sbox_inv [256];

  assign pending_blocks = block_queue.size();

  initial begin
    fail_count = 0;
    for (int i = 0; i < 256; i++) sbox_inv[Sbox[i]] = 8'(i);
  end

  function automatic int round_total();
    return (mode_q == KEY_128) ? 10 : (mode_q == KEY_192) ? 12 : 14;
  endfunction

  function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
    logic [7:0] p;
    p = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p ^= a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [31:0] mix_word(input logic [31:0] w, input bit inv);
    logic [7:0] mf [4];
    logic [7:0] mi [4];
    logic [7:0] col [4];
    logic [7:0] acc;
    logic [31:0] res;
    mf = '{8'd2, 8'd3, 8'd1, 8'd1};
    mi = '{8'd14, 8'd11, 8'd13, 8'd9};
    for (int k = 0; k < 4; k++) col[k] = w[31-8*k -: 8];
    for (int r = 0; r < 4; r++) begin
      acc = 8'h00;
      for (int k = 0; k < 4; k++)
        acc ^= gf_mul(inv ? mi[(k+4-r)&3] : mf[(k+4-r)&3], col[k]);
      res[31-8*r -: 8] = acc;
    end
    return res;
  endfunction

  task automatic build_schedule();
    int nk, total;
    logic [31:0] t;
    logic [7:0] rc;
    nk = (mode_q == KEY_128) ? 4 : (mode_q == KEY_192) ? 6 : 8;
    total = 4 * (round_total() + 1);
    rc = 8'h01;
    for (int i = 0; i < nk; i++)
      sched_q[i] = i[0] ? key_q[i/2][31:0] : key_q[i/2][63:32];
    for (int i = nk; i < total; i++) begin
      t = sched_q[i-1];
      if (i % nk == 0) begin
        t = {t[23:0], t[31:24]};
        t = {Sbox[t[31:24]], Sbox[t[23:16]], Sbox[t[15:8]], Sbox[t[7:0]]};
        t ^= {rc, 24'h0};
        rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
      end else if (nk > 6 && i % nk == 4) begin
        t = {Sbox[t[31:24]], Sbox[t[23:16]], Sbox[t[15:8]], Sbox[t[7:0]]};
      end
      sched_q[i] = sched_q[i-nk] ^ t;
    end
    sched_valid = 1;
  endtask

  function automatic out_item_t transform_block(input in_item_t it);
    logic [7:0] s [16];
    logic [7:0] t [16];
    logic [127:0] blk;
    int nr, rnd, src;
    bit inv;
    nr = round_total();
    inv = (it.op == OP_DECRYPT);
    blk = {it.block_high, it.block_low};
    for (int i = 0; i < 16; i++) s[i] = blk[127-8*i -: 8];
    for (int step = 0; step <= nr; step++) begin
      rnd = inv ? nr - step : step;
      if (step > 0) begin
        for (int c = 0; c < 4; c++)
          for (int r = 0; r < 4; r++) begin
            src = inv ? (c + 4 - r) & 3 : (c + r) & 3;
            t[4*c+r] = inv ? sbox_inv[s[4*src+r]] : Sbox[s[4*src+r]];
          end
        s = t;
        if (!inv && step != nr) begin
          for (int c = 0; c < 4; c++)
            {s[4*c], s[4*c+1], s[4*c+2], s[4*c+3]} =
              mix_word({s[4*c], s[4*c+1], s[4*c+2], s[4*c+3]}, inv);
        end
      end
      for (int c = 0; c < 4; c++)
        for (int r = 0; r < 4; r++)
          s[4*c+r] ^= sched_q[rnd*4+c][31-8*r -: 8];
      if (inv && step > 0 && step != nr) begin
        for (int c = 0; c < 4; c++)
          {s[4*c], s[4*c+1], s[4*c+2], s[4*c+3]} =
            mix_word({s[4*c], s[4*c+1], s[4*c+2], s[4*c+3]}, inv);
      end
    end
    for (int i = 0; i < 16; i++) blk[127-8*i -: 8] = s[i];
    return out_item_t'(blk);
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $realtime, what);
    fail_count++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t want;
    if (!rst_ni) begin
      mode_q = KEY_128;
      for (int i = 0; i < 4; i++) key_q[i] = '0;
      sched_valid = 0;
      block_queue.delete();
    end else begin
      if (done_o) begin
        if (block_queue.size() == 0) begin
          report_mismatch("result with no block outstanding");
        end else begin
          want = block_queue.pop_front();
          if (out_item_o.result_high !== want.result_high)
            report_mismatch($sformatf("result_high %h, expected %h",
                                      out_item_o.result_high, want.result_high));
          if (out_item_o.result_low !== want.result_low)
            report_mismatch($sformatf("result_low %h, expected %h",
                                      out_item_o.result_low, want.result_low));
        end
      end
      if (start_i && !busy_o) begin
        if (!sched_valid) build_schedule();
        block_queue.push_back(transform_block(in_item_i));
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_KEY_MODE) begin
          mode_q = cfg_data_i[1:0];
          sched_valid = 0;
        end else if (cfg_idx_i <= REG_KEY_24_31) begin
          key_q[cfg_idx_i - 1] = cfg_data_i;
          sched_valid = 0;
        end
      end
    end
  end

endmodule

@@ sim/tb_block_cipher_encrypt_decrypt_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// AES ECB core testbench
// Drives key settings and blocks in both directions through the core under
// varying idle patterns; the checker predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_block_cipher_encrypt_decrypt_core;
  import aes_pkg::*;

  logic                clk_i = 0;
  logic                rst_ni = 0;
  logic                cfg_we_i = 0;
  logic [CfgIdxW-1:0]  cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;
  logic                start_i = 0;
  in_item_t            in_item_i = '0;
  logic                busy_o;
  logic                done_o;
  out_item_t           out_item_o;
  int                  fail_count;
  int                  pending_blocks;
  int                  quiet_cycles = 0;
  int                  idle_pct = 0;

  localparam int QuietLimit = 5000;

  always #5 clk_i = ~clk_i;

  block_cipher_encrypt_decrypt_core dut (.*);

  aes_ecb_checker checker_i (.*);

  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || done_o || cfg_we_i) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > QuietLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] rand_word64();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return {$urandom(), $urandom()};
    endcase
  endfunction

  task automatic write_key_reg(input cfg_reg_e idx, input logic [63:0] value);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
  endtask

  task automatic write_stray_index();
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgIdxW'($urandom_range(5, 7));
    cfg_data_i <= rand_word64();
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  task automatic drain_blocks();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (pending_blocks != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic load_key(input logic [1:0] mode, input logic [63:0] k0,
                          input logic [63:0] k1, input logic [63:0] k2,
                          input logic [63:0] k3);
    drain_blocks();
    write_key_reg(REG_KEY_MODE, {62'h0, mode});
    write_key_reg(REG_KEY_0_7, k0);
    write_key_reg(REG_KEY_8_15, k1);
    write_key_reg(REG_KEY_16_23, k2);
    write_key_reg(REG_KEY_24_31, k3);
    cfg_we_i <= 1'b0;
  endtask

  task automatic send_block(input logic op, input logic [63:0] hi, input logic [63:0] lo);
    while ($urandom_range(0, 99) < idle_pct) begin
      start_i <= 1'b0;
      @(posedge clk_i);
    end
    start_i   <= 1'b1;
    in_item_i <= '{op: op, block_high: hi, block_low: lo};
    do @(posedge clk_i); while (busy_o);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Blocks before any key write use the all-zero 128-bit key.
    send_block(OP_ENCRYPT, '0, '0);
    send_block(OP_DECRYPT, '1, '1);
    load_key(KEY_128, 64'h2b7e151628aed2a6, 64'habf7158809cf4f3c, '1, '1);
    send_block(OP_ENCRYPT, 64'h3243f6a8885a308d, 64'h313198a2e0370734);
    send_block(OP_DECRYPT, 64'h3925841d02dc09fb, 64'hdc118597196a0b32);
    load_key(KEY_192, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, '0);
    send_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(OP_DECRYPT, 64'h8000000000000000, 64'h0000000000000001);
    load_key(KEY_256, '1, '1, '1, '1);
    send_block(OP_ENCRYPT, '1, '0);
    send_block(OP_DECRYPT, '0, '1);
    // Key mode three behaves as a 256-bit key.
    load_key(2'd3, 64'h0001020304050607, 64'h08090a0b0c0d0e0f,
             64'h1011121314151617, 64'h18191a1b1c1d1e1f);
    send_block(OP_ENCRYPT, 64'h0011223344556677, 64'h8899aabbccddeeff);
    send_block(OP_DECRYPT, 64'h8ea2b7ca516745bf, 64'heafc49904b496089);
    // A write to an unused index changes nothing.
    drain_blocks();
    write_stray_index();
    send_block(OP_ENCRYPT, 64'h0123456789abcdef, 64'hfedcba9876543210);

    for (int phase = 0; phase < 3; phase++) begin
      idle_pct = (phase == 0) ? 30 : (phase == 1) ? 63 : 0;
      for (int n = 0; n < 300; n++) begin
        if (n % 25 == 0) begin
          load_key(2'($urandom_range(0, 3)), rand_word64(), rand_word64(),
                   rand_word64(), rand_word64());
          if ($urandom_range(0, 3) == 0) write_stray_index();
        end
        send_block(1'($urandom_range(0, 1)), rand_word64(), rand_word64());
      end
    end

    drain_blocks();
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule
